/* src/cbm_pkg.sv */
package cbm_pkg;

  // operation codes
  localparam logic [2:0] OP_CPU_RD = 3'd0;
  localparam logic [2:0] OP_CPU_WR = 3'd1;
  localparam logic [2:0] OP_PPU_RD = 3'd2;
  localparam logic [2:0] OP_PPU_WR = 3'd3;
  localparam logic [2:0] OP_NT_MAP = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  // target codes
  localparam logic [2:0] TG_NONE   = 3'd0;
  localparam logic [2:0] TG_REG    = 3'd1;
  localparam logic [2:0] TG_WRAM   = 3'd2;
  localparam logic [2:0] TG_PRG    = 3'd3;
  localparam logic [2:0] TG_CHR    = 3'd4;
  localparam logic [2:0] TG_CIRAM  = 3'd5;
  localparam logic [2:0] TG_ABSORB = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_BANKS = 2'd0;
  localparam logic [1:0] CFG_CHR_BANKS = 2'd1;
  localparam logic [1:0] CFG_PRG_RAM   = 2'd2;

  // constants
  localparam logic [14:0] CNT_MAX      = 15'h7FFF;
  localparam logic [7:0]  NT_INTERNAL  = 8'hE0;
  localparam logic [7:0]  PRG_MASK     = 8'h3F;
  localparam logic [7:0]  HI_MASK      = 8'h7F;
  localparam logic [6:0]  PRG_BANK_MAX = 7'd64;
  localparam int          MOD_STEPS    = 8;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] mem_address;
    logic [7:0]  read_data;
    logic        irq_out;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOAD
  } state_t;

endpackage

/* src/cbm_mod_unit.sv */
module cbm_mod_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [8:0] divisor,
  output logic       done,
  output logic [8:0] remainder
);

  logic [3:0] cnt;
  logic       busy;
  logic [7:0] dvd;
  logic [8:0] div;
  logic [9:0] trial;

  // one restoring step per cycle, most significant bit first
  assign trial = {remainder, dvd[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(cbm_pkg::MOD_STEPS);
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      div       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[6:0], 1'b0};
      if (trial >= {1'b0, div}) begin
        remainder <= 9'(trial - {1'b0, div});
      end else begin
        remainder <= trial[8:0];
      end
    end
  end

endmodule

/* src/cartridge_bank_mapper_with_irq.sv */
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data   (cbm_pkg::in_word_t)
// out       output     out_valid / out_ready  out_data  (cbm_pkg::out_word_t)
// cfg       input      cfg_write              cfg_index, cfg_data
//
// A word needing a bank reduction passes through eight steps of the shared
// bit-serial remainder unit, then bank insertion, then the load into the
// result register; other words go from accept straight to the load.
// in_ready drops after an accept and returns the cycle after the load, so
// one word is in flight at a time: a new word waits until the last is loaded.
// Reset is synchronous; all bank, counter and control state is restored.
// A stalled result holds only the final load stage; in_ready returns as
// soon as the result register has been loaded.
module cartridge_bank_mapper_with_irq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cbm_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cbm_pkg::out_word_t out_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  cbm_pkg::state_t state, state_next;

  logic [6:0] cfg_prg;
  logic [8:0] cfg_chr;
  logic       cfg_ram;

  logic [7:0]  pat_bank [8];
  logic [7:0]  nt_bank  [4];
  logic [5:0]  prg_bank [3];
  logic [14:0] irq_count;
  logic        irq_enable;
  logic        irq_pending;

  // pending result
  logic [2:0]  pend_tg;
  logic [18:0] pend_ma;
  logic [7:0]  pend_rd;
  logic        pend_prg;

  // decode results
  logic [2:0]  dec_tg;
  logic [18:0] dec_ma;
  logic [7:0]  dec_rd;
  logic        dec_mod;
  logic        dec_prg;
  logic [7:0]  dec_bank;
  logic [8:0]  dec_div;

  logic [6:0]  prg_n;
  logic [15:0] a;
  logic [7:0]  pbank;
  logic [7:0]  nbank;
  logic        accept;
  logic        mod_start;
  logic        mod_done;
  logic [8:0]  mod_rem;
  logic        load;

  assign a      = in_data.bus_address;
  assign prg_n  = (cfg_prg > cbm_pkg::PRG_BANK_MAX) ? cbm_pkg::PRG_BANK_MAX : cfg_prg;
  assign pbank  = pat_bank[a[12:10]];
  assign nbank  = nt_bank[a[11:10]];
  assign accept = in_valid && in_ready;

  // address decode
  always_comb begin
    dec_tg   = cbm_pkg::TG_NONE;
    dec_ma   = '0;
    dec_rd   = '0;
    dec_mod  = 1'b0;
    dec_prg  = 1'b0;
    dec_bank = '0;
    dec_div  = cfg_chr;
    case (in_data.operation)
      cbm_pkg::OP_CPU_RD, cbm_pkg::OP_CPU_WR: begin
        if (a >= 16'h6000 && a <= 16'h7FFF) begin
          if (cfg_ram) begin
            dec_tg = cbm_pkg::TG_WRAM;
            dec_ma = {6'd0, a[12:0]};
          end else begin
            dec_tg = cbm_pkg::TG_ABSORB;
          end
        end else if (in_data.operation == cbm_pkg::OP_CPU_RD) begin
          if (a >= 16'h4800 && a <= 16'h4FFF) begin
            dec_tg = cbm_pkg::TG_REG;
            dec_rd = irq_count[7:0];
          end else if (a >= 16'h5000 && a <= 16'h57FF) begin
            dec_tg = cbm_pkg::TG_REG;
            dec_rd = {1'b0, irq_count[14:8]};
          end else if (a >= 16'h8000) begin
            if (prg_n == 7'd0) begin
              dec_tg = cbm_pkg::TG_ABSORB;
            end else begin
              dec_tg  = cbm_pkg::TG_PRG;
              dec_ma  = {6'd0, a[12:0]};
              dec_mod = 1'b1;
              dec_prg = 1'b1;
              dec_div = {2'd0, prg_n};
              case (a[14:13])
                2'd0:    dec_bank = {2'd0, prg_bank[0]};
                2'd1:    dec_bank = {2'd0, prg_bank[1]};
                2'd2:    dec_bank = {2'd0, prg_bank[2]};
                default: dec_bank = {1'b0, 7'(prg_n - 7'd1)};
              endcase
            end
          end
        end else if (a >= 16'h5000 && a <= 16'hF7FF) begin
          dec_tg = cbm_pkg::TG_REG;
        end
      end
      cbm_pkg::OP_PPU_RD, cbm_pkg::OP_PPU_WR: begin
        if (a < 16'h2000 && cfg_chr != 9'd0 && pbank < cbm_pkg::NT_INTERNAL) begin
          dec_tg   = cbm_pkg::TG_CHR;
          dec_ma   = {9'd0, a[9:0]};
          dec_mod  = 1'b1;
          dec_bank = pbank;
        end
      end
      cbm_pkg::OP_NT_MAP: begin
        if (nbank >= cbm_pkg::NT_INTERNAL) begin
          dec_tg = cbm_pkg::TG_CIRAM;
          dec_ma = {8'd0, nbank[0], a[9:0]};
        end else if (cfg_chr != 9'd0) begin
          dec_tg   = cbm_pkg::TG_CHR;
          dec_ma   = {9'd0, a[9:0]};
          dec_mod  = 1'b1;
          dec_bank = nbank;
        end
      end
      default: begin
        dec_tg = cbm_pkg::TG_NONE;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mod_start  = 1'b0;
    load       = 1'b0;
    case (state)
      cbm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mod_start  = dec_mod;
          state_next = dec_mod ? cbm_pkg::ST_CALC : cbm_pkg::ST_LOAD;
        end
      end
      cbm_pkg::ST_CALC: begin
        if (mod_done) begin
          state_next = cbm_pkg::ST_LOAD;
        end
      end
      cbm_pkg::ST_LOAD: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = cbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_prg <= 7'd2;
      cfg_chr <= 9'd8;
      cfg_ram <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        cbm_pkg::CFG_PRG_BANKS: cfg_prg <= cfg_data[6:0];
        cbm_pkg::CFG_CHR_BANKS: cfg_chr <= cfg_data;
        cbm_pkg::CFG_PRG_RAM:   cfg_ram <= cfg_data[0];
        default:                cfg_ram <= cfg_ram;
      endcase
    end
  end

  // bank registers and irq counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        pat_bank[i] <= '0;
      end
      nt_bank[0]  <= 8'hE0;
      nt_bank[1]  <= 8'hE1;
      nt_bank[2]  <= 8'hE0;
      nt_bank[3]  <= 8'hE1;
      prg_bank[0] <= 6'd0;
      prg_bank[1] <= 6'd1;
      prg_bank[2] <= 6'd2;
      irq_count   <= '0;
      irq_enable  <= 1'b0;
      irq_pending <= 1'b0;
    end else if (accept) begin
      if (in_data.operation == cbm_pkg::OP_CPU_WR) begin
        if (a >= 16'h5000 && a <= 16'h57FF) begin
          irq_count[7:0] <= in_data.write_data;
          irq_pending    <= 1'b0;
        end else if (a >= 16'h5800 && a <= 16'h5FFF) begin
          irq_count[14:8] <= 7'(in_data.write_data & cbm_pkg::HI_MASK);
          irq_enable      <= in_data.write_data[7];
          irq_pending     <= 1'b0;
        end else if (a >= 16'h8000 && a <= 16'hBFFF) begin
          pat_bank[a[13:11]] <= in_data.write_data;
        end else if (a >= 16'hC000 && a <= 16'hDFFF) begin
          nt_bank[a[12:11]] <= in_data.write_data;
        end else if (a >= 16'hE000 && a <= 16'hF7FF) begin
          prg_bank[2'(a[12:11])] <= 6'(in_data.write_data & cbm_pkg::PRG_MASK);
        end
      end else if (in_data.operation == cbm_pkg::OP_TICK) begin
        if (irq_enable && irq_count < cbm_pkg::CNT_MAX) begin
          irq_count <= irq_count + 15'd1;
          if (irq_count == 15'(cbm_pkg::CNT_MAX - 15'd1)) begin
            irq_pending <= 1'b1;
          end
        end
      end
    end
  end

  // shared remainder unit
  cbm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (dec_bank),
    .divisor   (dec_div),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // pending result capture and bank insertion
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_tg  <= dec_tg;
      pend_ma  <= dec_ma;
      pend_rd  <= dec_rd;
      pend_prg <= dec_prg;
    end else if (state == cbm_pkg::ST_CALC && mod_done) begin
      if (pend_prg) begin
        pend_ma <= {mod_rem[5:0], pend_ma[12:0]};
      end else begin
        pend_ma <= {1'b0, mod_rem[7:0], pend_ma[9:0]};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.target      <= pend_tg;
      out_data.mem_address <= pend_ma;
      out_data.read_data   <= pend_rd;
      out_data.irq_out     <= irq_pending;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted while previous word still in progress");

  a_pending_at_max : assert property (@(posedge clk) disable iff (rst)
    irq_pending |-> irq_count == cbm_pkg::CNT_MAX)
    else $error("irq pending without counter at terminal value");

  a_calc_to_load : assert property (@(posedge clk) disable iff (rst)
    (state == cbm_pkg::ST_CALC && mod_done) |=> state == cbm_pkg::ST_LOAD)
    else $error("remainder unit finished out of sequence");

  a_no_addr_on_reg : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.target == cbm_pkg::TG_NONE
      || out_data.target == cbm_pkg::TG_REG
      || out_data.target == cbm_pkg::TG_ABSORB)) |-> out_data.mem_address == '0)
    else $error("address given for a target without memory");

  a_done_only_in_calc : assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == cbm_pkg::ST_CALC)
    else $error("remainder done outside calculation state");
`endif

endmodule
